@@ hw/rtl/eqs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_pkg: shared types and constants of the empirical quality sampler
// Sizes, register indexes, status codes and the sequencer state encoding.
// ----------------------------------------------------------------------------
package eqs_pkg;
	localparam int unsigned POSITIONS = 256;
	localparam int unsigned ENTRIES   = 64;
	localparam int unsigned SCALE     = 1000000;
	localparam int unsigned POS_W     = $clog2(POSITIONS);
	localparam int unsigned ENT_W     = $clog2(ENTRIES);
	localparam int unsigned ROWS      = 8 * POSITIONS;
	localparam int unsigned ROW_W     = $clog2(ROWS);
	localparam int unsigned ADDR_W    = ROW_W + ENT_W;
	localparam int unsigned LEN_W     = $clog2(ENTRIES + 1);
	localparam int unsigned KEY_W     = 20;
	localparam int unsigned QUAL_W    = 7;
	localparam int unsigned NUM_W     = 52;
	localparam int unsigned DIV_CNT_W = $clog2(NUM_W + 1);
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	localparam logic [2:0] REG_SEP   = 3'd0;
	localparam logic [2:0] REG_SHIFT1 = 3'd1;
	localparam logic [2:0] REG_SHIFT2 = 3'd2;
	localparam logic [2:0] REG_MINQ  = 3'd3;
	localparam logic [2:0] REG_MAXQ  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_UNCOVER  = 2'd2;
	localparam logic [1:0] ST_ZERO_TOT = 2'd3;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_LOOK  = 9'b000000100,
		S_DIV   = 9'b000001000,
		S_WRITE = 9'b000010000,
		S_LEN   = 9'b000100000,
		S_READ  = 9'b001000000,
		S_CMP   = 9'b010000000,
		S_DONE  = 9'b100000000
	} state_t;
endpackage

@@ hw/rtl/empirical_quality_sampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// empirical_quality_sampler: per-position empirical quality sampler
// Loads scaled cumulative keys into rows and samples qualities by inverse CDF.
// ----------------------------------------------------------------------------
// One item at a time. After reset the block holds busy while it clears the row
// lengths, one row per cycle. A load holds busy after its transfer while it
// launches the bit-serial divider, waits for the quotient bits and sees it
// finish, then does the entry write, the length update of a closing load and the result.
// A sample reads the row length, then scans the row linearly through the
// single key/quality memory port, reading and then comparing each entry, up to
// a full row of 64 entries; an empty row ends at the length read. A load with
// a zero total and any item for an other base in per-base mode go straight to
// the result. Each item gives exactly one result, shown for one cycle on strobe
// in the cycle in which busy falls, and a new item may be transferred in that
// same cycle; the receiver cannot stall, so the result is simply presented and
// the block returns to idle.
module empirical_quality_sampler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic        read_sel,
	input  logic [2:0]  base_code,
	input  logic [7:0]  position,
	input  logic [5:0]  entry_index,
	input  logic        last_entry,
	input  logic [31:0] cum_count,
	input  logic [31:0] row_total,
	input  logic [6:0]  quality_value,
	input  logic [19:0] random_draw,
	input  logic [3:0]  low_quality_draw,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [6:0]  cfg_data,
	output logic        strobe,
	output logic [6:0]  quality_out,
	output logic [1:0]  status
);
	import eqs_pkg::*;

	// configuration registers
	logic              sep_q;
	logic signed [6:0] shift1_q, shift2_q;
	logic [6:0]        minq_q, maxq_q;

	state_t            state_q;
	logic              rd_q, last_q;
	logic [ROW_W-1:0]  row_q;
	logic [ENT_W-1:0]  idx_q;
	logic [31:0]       cnt_q, tot_q;
	logic [6:0]        qv_q;
	logic [KEY_W-1:0]  draw_q;
	logic [LEN_W-1:0]  len_q, scan_q;
	logic              scan_run_q;
	logic [ROW_W-1:0]  clr_q;
	logic              found_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [QUAL_W-1:0] best_q_q;
	logic [6:0]        res_q_q;
	logic [1:0]        res_st_q;

	logic              div_start, div_done;
	logic [KEY_W-1:0]  div_key;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [KEY_W-1:0]  key_rd;
	logic [QUAL_W-1:0] qual_rd;
	logic              len_we;
	logic [ROW_W-1:0]  len_addr;
	logic [LEN_W-1:0]  len_wdata, len_rd;
	logic [1:0]        tbl;
	logic [ROW_W-1:0]  row_in;
	logic              accept;
	logic [6:0]        low_sat;
	logic signed [8:0] shifted;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign tbl       = sep_q ? base_code[1:0] : 2'd0;
	assign row_in    = {read_sel, tbl, position[POS_W-1:0]};
	assign low_sat   = (low_quality_draw > 4'd9) ? 7'd9 : 7'(low_quality_draw);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= 1'b0; shift1_q <= '0; shift2_q <= '0;
			minq_q <= '0; maxq_q <= 7'd127;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEP:    sep_q    <= cfg_data[0];
				REG_SHIFT1: shift1_q <= cfg_data;
				REG_SHIFT2: shift2_q <= cfg_data;
				REG_MINQ:   minq_q   <= cfg_data;
				REG_MAXQ:   maxq_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// row lengths: cleared by the pass after reset, read at the transfer, written
	// once the entry of a closing load is stored
	assign len_we    = (state_q == S_CLEAR) || (state_q == S_LEN && last_q);
	assign len_addr  = (state_q == S_CLEAR) ? clr_q
		: ((state_q == S_IDLE) ? row_in : row_q);
	assign len_wdata = (state_q == S_CLEAR) ? '0 : LEN_W'(idx_q) + LEN_W'(1);

	eqs_ram #(.WIDTH(LEN_W), .DEPTH(ROWS)) u_len_ram (
		.clk(clk), .we(len_we), .addr(len_addr), .wdata(len_wdata), .rdata(len_rd)
	);

	assign div_start = (state_q == S_DIV) && (scan_q == '0);

	eqs_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.count(cnt_q), .total(tot_q), .done(div_done), .key(div_key)
	);

	assign ram_we   = (state_q == S_WRITE);
	assign ram_addr = ram_we ? {row_q, idx_q} : {row_q, scan_q[ENT_W-1:0]};

	eqs_ram #(.WIDTH(KEY_W), .DEPTH(ROWS * ENTRIES)) u_key_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(div_key), .rdata(key_rd)
	);
	eqs_ram #(.WIDTH(QUAL_W), .DEPTH(ROWS * ENTRIES)) u_qual_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(qv_q), .rdata(qual_rd)
	);

	assign shifted = 9'(signed'({2'b00, best_q_q})) +
		9'(rd_q ? shift2_q : shift1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			strobe     <= 1'b0;
			clr_q      <= '0;
			scan_q     <= '0;
			scan_run_q <= 1'b0;
			rd_q <= 1'b0; last_q <= 1'b0; row_q <= '0; idx_q <= '0;
			cnt_q <= '0; tot_q <= '0; qv_q <= '0; draw_q <= '0; len_q <= '0;
			found_q <= 1'b0; best_key_q <= '0; best_q_q <= '0;
			res_q_q <= '0; res_st_q <= ST_OK;
		end else begin
			strobe <= (state_q == S_DONE);
			unique case (state_q)
				S_CLEAR: begin
					// zero one row length per cycle
					clr_q <= clr_q + 1'b1;
					if (clr_q == ROW_W'(ROWS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						scan_q     <= '0;
						scan_run_q <= 1'b0;
						found_q    <= 1'b0;
						// hold the item
						rd_q <= read_sel; last_q <= last_entry; row_q <= row_in;
						idx_q <= entry_index[ENT_W-1:0]; cnt_q <= cum_count;
						tot_q <= row_total; qv_q <= quality_value;
						draw_q <= random_draw;
						if (sep_q && base_code > 3'd3) begin
							res_q_q  <= operation ? low_sat : 7'd0;
							res_st_q <= ST_OK;
							state_q  <= S_DONE;
						end else if (!operation) begin
							res_q_q <= '0;
							if (row_total == '0) begin
								res_st_q <= ST_ZERO_TOT;
								state_q  <= S_DONE;
							end else begin
								res_st_q <= ST_OK;
								state_q  <= S_DIV;
							end
						end else begin
							res_q_q  <= '0;
							res_st_q <= ST_OK;
							state_q  <= S_LOOK;
						end
					end
				end
				S_LOOK: begin
					// row length arrives from the length memory
					len_q <= len_rd;
					if (len_rd == '0) begin
						res_st_q <= ST_EMPTY;
						state_q  <= S_DONE;
					end else begin
						scan_run_q <= 1'b1;
						state_q    <= S_READ;
					end
				end
				S_DIV: begin
					// scan_q marks that the divider is launched
					scan_q <= LEN_W'(1);
					if (div_done) state_q <= S_WRITE;
				end
				S_WRITE: state_q <= S_LEN;
				S_LEN:   state_q <= S_DONE;
				S_READ:  state_q <= S_CMP;
				S_CMP: begin
					// later entry with equal key overrides
					if (key_rd >= draw_q && (!found_q || key_rd <= best_key_q)) begin
						found_q <= 1'b1;
						best_key_q <= key_rd;
						best_q_q <= qual_rd;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 == len_q) state_q <= S_DONE;
					else state_q <= S_READ;
				end
				S_DONE: begin
					state_q <= S_IDLE;
					if (scan_run_q) begin
						if (!found_q) begin
							res_st_q <= ST_UNCOVER;
							res_q_q <= '0;
						end else if (shifted > 9'sd127 || shifted > signed'({2'b0, maxq_q}))
							res_q_q <= maxq_q;
						else if (shifted < signed'({2'b0, minq_q}))
							res_q_q <= (minq_q > maxq_q) ? maxq_q : minq_q;
						else
							res_q_q <= shifted[6:0];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign quality_out = res_q_q;
	assign status      = res_st_q;

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> state_q == S_IDLE) else $error("strobe outside idle");
	a_write_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> $past(state_q) == S_DIV) else $error("write without division");
endmodule

@@ hw/rtl/eqs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module eqs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ hw/rtl/eqs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqs_div: restoring divider, one quotient bit per cycle
// Computes ceil(count*SCALE/total) saturated to the key range.
// ----------------------------------------------------------------------------
module eqs_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [31:0]                count,
	input  logic [31:0]                total,
	output logic                       done,
	output logic [eqs_pkg::KEY_W-1:0]  key
);
	import eqs_pkg::*;

	logic [NUM_W-1:0]     num_q;
	logic [NUM_W-1:0]     quo_q;
	logic [32:0]          rem_q;
	logic [31:0]          den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [NUM_W-1:0]     prod;
	logic [32:0]          trial;
	logic [32:0]          diff;

	// count*SCALE fits in 52 bits; add total-1 for the ceiling
	assign prod  = NUM_W'({20'd0, count} * NUM_W'(SCALE)) + NUM_W'(total) - NUM_W'(1);
	assign trial = {rem_q[31:0], num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= prod;
			den_q <= total;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign key = (|quo_q[NUM_W-1:KEY_W]) ? KEY_MAX : quo_q[KEY_W-1:0];
endmodule
